[rtl/spht_pkg.sv]
// Shared types, widths and constants of the shape pair hit test pipeline.
package spht_pkg;

    localparam int COORD_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FIELD_BITS        = 16;
    localparam int ATAN_COUNT        = 24;

    // CORDIC datapath widths: x and y in Q2.30 with headroom, angle as a turn fraction.
    localparam int XW = 34;
    localparam int ZW = 33;
    localparam int FRAC = 30;
    // Width of the exact rotated-center compares.
    localparam int WW = 56;

    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [2:0] KIND_RECT = 3'd0;
    localparam logic [2:0] KIND_CIRC = 3'd1;
    localparam logic [2:0] KIND_RA   = 3'd2;
    localparam logic [2:0] KIND_AR   = 3'd3;

    localparam logic [31:0] ATAN_TURN [ATAN_COUNT] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } spht_cordic_t;

    // Operands of the rotated test plus the already resolved simple result.
    typedef struct packed {
        logic               simple_hit;
        logic               rot;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic [14:0]        bw;
        logic [14:0]        bh;
        logic [14:0]        rw;
        logic [14:0]        rh;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
    } spht_pld_t;

endpackage

[rtl/spht_prep.sv]
// Input stages: field decoding, rectangle and circle tests, CORDIC angle setup.
module spht_prep #(
    parameter int COORD_BITS = spht_pkg::COORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [2:0]                kind,
    input  logic signed [15:0]        a_x,
    input  logic signed [15:0]        a_y,
    input  logic [14:0]               a_width,
    input  logic [14:0]               a_height,
    input  logic [14:0]               a_radius,
    input  logic signed [15:0]        b_x,
    input  logic signed [15:0]        b_y,
    input  logic [14:0]               b_width,
    input  logic [14:0]               b_height,
    input  logic [14:0]               b_radius,
    input  logic [15:0]               rot_angle,
    output logic                      out_valid,
    output spht_pkg::spht_cordic_t    out_cordic,
    output spht_pkg::spht_pld_t       out_pld
);

    localparam int CW  = (COORD_BITS < spht_pkg::FIELD_BITS) ? COORD_BITS
                                                             : spht_pkg::FIELD_BITS;
    localparam int SW  = CW - 1;
    localparam int CSH = spht_pkg::FIELD_BITS - CW;
    localparam logic [14:0] SMASK = 15'((32'd1 << SW) - 32'd1);
    localparam int ZW_L = spht_pkg::ZW;

    logic signed [15:0] ax_c, ay_c, bx_c, by_c;
    logic [14:0]        aw_c, ah_c, ar_c, bw_c, bh_c, br_c;
    logic signed [18:0] ax2, ay2, bx2, by2, aws, ahs, bws, bhs;
    logic               box_hit;
    logic               swap;
    logic [31:0]        z32;
    logic               flip;
    logic [31:0]        zf;

    // Stage 1 registers.
    logic               v1_reg;
    logic               is_rect_reg, is_circ_reg, box_reg;
    logic signed [16:0] cdx_reg, cdy_reg;
    logic [15:0]        rs_reg;
    logic signed [ZW_L-1:0] z1_reg;
    logic               flip1_reg;
    spht_pkg::spht_pld_t pld1_reg, pld1_next;

    // Stage 2 registers.
    logic               v2_reg;
    logic               is_rect2_reg, is_circ2_reg, box2_reg;
    logic [33:0]        sqx_reg, sqy_reg;
    logic [31:0]        sqr_reg;
    logic signed [ZW_L-1:0] z2_reg;
    logic               flip2_reg;
    spht_pkg::spht_pld_t pld2_reg;

    // Stage 3 registers.
    logic               v3_reg;
    spht_pkg::spht_pld_t pld3_reg, pld3_next;
    logic signed [ZW_L-1:0] z3_reg;
    logic               flip3_reg;

    logic [34:0]        sq_sum;
    logic               circ_hit;

    // Keep only the low coordinate bits, sign-extended.
    assign ax_c = (a_x <<< CSH) >>> CSH;
    assign ay_c = (a_y <<< CSH) >>> CSH;
    assign bx_c = (b_x <<< CSH) >>> CSH;
    assign by_c = (b_y <<< CSH) >>> CSH;
    assign aw_c = a_width & SMASK;
    assign ah_c = a_height & SMASK;
    assign ar_c = a_radius & SMASK;
    assign bw_c = b_width & SMASK;
    assign bh_c = b_height & SMASK;
    assign br_c = b_radius & SMASK;

    assign ax2 = 19'(ax_c) <<< 1;
    assign ay2 = 19'(ay_c) <<< 1;
    assign bx2 = 19'(bx_c) <<< 1;
    assign by2 = 19'(by_c) <<< 1;
    assign aws = $signed(19'(aw_c));
    assign ahs = $signed(19'(ah_c));
    assign bws = $signed(19'(bw_c));
    assign bhs = $signed(19'(bh_c));

    assign box_hit = (ax2 - aws <= bx2 + bws) && (bx2 - bws <= ax2 + aws)
                  && (ay2 - ahs <= by2 + bhs) && (by2 - bhs <= ay2 + ahs);

    // Angles in the second and third quarter turn are folded by half a turn.
    assign z32  = {rot_angle, 16'h0000};
    assign flip = (z32[31:30] == 2'd1) || (z32[31:30] == 2'd2);
    assign zf   = flip ? (z32 ^ 32'h8000_0000) : z32;

    assign swap = (kind == spht_pkg::KIND_AR);

    always_comb
    begin
        pld1_next            = '0;
        pld1_next.simple_hit = 1'b0;
        pld1_next.rot        = (kind == spht_pkg::KIND_RA) || (kind == spht_pkg::KIND_AR);
        pld1_next.bx         = swap ? ax_c : bx_c;
        pld1_next.by         = swap ? ay_c : by_c;
        pld1_next.bw         = swap ? aw_c : bw_c;
        pld1_next.bh         = swap ? ah_c : bh_c;
        pld1_next.rw         = swap ? bw_c : aw_c;
        pld1_next.rh         = swap ? bh_c : ah_c;
        pld1_next.dx         = swap ? (17'(bx_c) - 17'(ax_c)) : (17'(ax_c) - 17'(bx_c));
        pld1_next.dy         = swap ? (17'(by_c) - 17'(ay_c)) : (17'(ay_c) - 17'(by_c));
    end

    assign sq_sum   = 35'(sqx_reg) + 35'(sqy_reg);
    assign circ_hit = sq_sum <= 35'(sqr_reg);

    always_comb
    begin
        pld3_next            = pld2_reg;
        pld3_next.simple_hit = (is_rect2_reg && box2_reg) || (is_circ2_reg && circ_hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        is_rect_reg  <= (kind == spht_pkg::KIND_RECT);
        is_circ_reg  <= (kind == spht_pkg::KIND_CIRC);
        box_reg      <= box_hit;
        cdx_reg      <= 17'(ax_c) - 17'(bx_c);
        cdy_reg      <= 17'(ay_c) - 17'(by_c);
        rs_reg       <= 16'(ar_c) + 16'(br_c);
        z1_reg       <= ZW_L'($signed(zf));
        flip1_reg    <= flip;
        pld1_reg     <= pld1_next;

        is_rect2_reg <= is_rect_reg;
        is_circ2_reg <= is_circ_reg;
        box2_reg     <= box_reg;
        sqx_reg      <= 34'(cdx_reg) * 34'(cdx_reg);
        sqy_reg      <= 34'(cdy_reg) * 34'(cdy_reg);
        sqr_reg      <= 32'(rs_reg) * 32'(rs_reg);
        z2_reg       <= z1_reg;
        flip2_reg    <= flip1_reg;
        pld2_reg     <= pld1_reg;

        pld3_reg     <= pld3_next;
        z3_reg       <= z2_reg;
        flip3_reg    <= flip2_reg;
    end

    assign out_valid       = v3_reg;
    assign out_pld         = pld3_reg;
    assign out_cordic.x    = spht_pkg::CORDIC_GAIN;
    assign out_cordic.y    = '0;
    assign out_cordic.z    = z3_reg;
    assign out_cordic.flip = flip3_reg;

endmodule

[rtl/spht_cell.sv]
// One CORDIC rotation cell: a single micro-rotation and its register.
module spht_cell #(
    parameter int IDX = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  spht_pkg::spht_cordic_t    in_cordic,
    input  spht_pkg::spht_pld_t       in_pld,
    output logic                      out_valid,
    output spht_pkg::spht_cordic_t    out_cordic,
    output spht_pkg::spht_pld_t       out_pld
);

    localparam logic signed [spht_pkg::ZW-1:0] ATAN =
        $signed({1'b0, spht_pkg::ATAN_TURN[IDX]});

    logic                            valid_reg;
    spht_pkg::spht_cordic_t          cordic_reg, cordic_next;
    spht_pkg::spht_pld_t             pld_reg;
    logic signed [spht_pkg::XW-1:0]  xs, ys;

    assign xs = in_cordic.x >>> IDX;
    assign ys = in_cordic.y >>> IDX;

    always_comb
    begin
        cordic_next = in_cordic;
        if (!in_cordic.z[spht_pkg::ZW-1])
        begin
            cordic_next.x = in_cordic.x - ys;
            cordic_next.y = in_cordic.y + xs;
            cordic_next.z = in_cordic.z - ATAN;
        end
        else
        begin
            cordic_next.x = in_cordic.x + ys;
            cordic_next.y = in_cordic.y - xs;
            cordic_next.z = in_cordic.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cordic_reg <= cordic_next;
        pld_reg    <= in_pld;
    end

    assign out_valid  = valid_reg;
    assign out_cordic = cordic_reg;
    assign out_pld    = pld_reg;

endmodule

[rtl/spht_rot.sv]
// Output stages: rotate the rectangle center and test it against the box bounds.
module spht_rot (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  spht_pkg::spht_cordic_t    in_cordic,
    input  spht_pkg::spht_pld_t       in_pld,
    output logic                      done,
    output logic                      hit
);

    localparam int XW   = spht_pkg::XW;
    localparam int WW   = spht_pkg::WW;
    localparam int FRAC = spht_pkg::FRAC;
    localparam int PW   = XW + 17;

    logic                 v1_reg, v2_reg, v3_reg, done_reg;
    logic signed [XW-1:0] c_reg, s_reg;
    logic signed [PW-1:0] cdx_reg, sdy_reg, sdx_reg, cdy_reg;
    logic signed [WW-1:0] ax_reg, ay_reg;
    spht_pkg::spht_pld_t  pld1_reg, pld2_reg, pld3_reg;
    logic                 hit_reg, hit_next;

    logic signed [WW-1:0] ax2, ay2, rwq, rhq, bxq2, byq2, bwq2, bhq;
    logic                 in_box;

    assign ax2  = ax_reg <<< 1;
    assign ay2  = ay_reg <<< 1;
    assign rwq  = $signed(WW'(pld3_reg.rw)) <<< FRAC;
    assign rhq  = $signed(WW'(pld3_reg.rh)) <<< FRAC;
    assign bwq2 = $signed(WW'(pld3_reg.bw)) <<< (FRAC + 1);
    assign bhq  = $signed(WW'(pld3_reg.bh)) <<< FRAC;
    assign bxq2 = WW'($signed(pld3_reg.bx)) <<< (FRAC + 1);
    assign byq2 = WW'($signed(pld3_reg.by)) <<< (FRAC + 1);

    // Both sides are doubled so the half extents stay exact.
    assign in_box = (ax2 - rwq <= bxq2 + bwq2) && (bxq2 <= ax2 + rwq)
                 && (ay2 - rhq <= byq2 + bhq) && (byq2 - bhq <= ay2 + rhq);

    assign hit_next = pld3_reg.rot ? in_box : pld3_reg.simple_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg    <= in_cordic.flip ? -in_cordic.x : in_cordic.x;
        s_reg    <= in_cordic.flip ? -in_cordic.y : in_cordic.y;
        pld1_reg <= in_pld;

        cdx_reg  <= PW'(c_reg) * PW'(pld1_reg.dx);
        sdy_reg  <= PW'(s_reg) * PW'(pld1_reg.dy);
        sdx_reg  <= PW'(s_reg) * PW'(pld1_reg.dx);
        cdy_reg  <= PW'(c_reg) * PW'(pld1_reg.dy);
        pld2_reg <= pld1_reg;

        ax_reg   <= (WW'($signed(pld2_reg.bx)) <<< FRAC) + WW'(cdx_reg) + WW'(sdy_reg);
        ay_reg   <= (WW'($signed(pld2_reg.by)) <<< FRAC) - WW'(sdx_reg) + WW'(cdy_reg);
        pld3_reg <= pld2_reg;

        hit_reg  <= hit_next;
    end

    assign done = done_reg;
    assign hit  = hit_reg;

endmodule

[rtl/shape_pair_hit_test.sv]
// Top level of the shape pair hit test: input stages, CORDIC cell row, output stages.
// The done strobe follows each accepted item through three input stages, one CORDIC
// cell per stage up to 24, and four output stages.
// Throughput: one item per cycle unless busy; each cell and stage registers each clock.
// Reset clears all valid bits; busy is high during reset and the cycle after it.
// The receiver cannot stall: each result is on hit for the single cycle done is high.
module shape_pair_hit_test #(
    parameter int COORD_BITS    = spht_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STAGES = spht_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         kind,
    input  logic signed [15:0] a_x,
    input  logic signed [15:0] a_y,
    input  logic [14:0]        a_width,
    input  logic [14:0]        a_height,
    input  logic [14:0]        a_radius,
    input  logic signed [15:0] b_x,
    input  logic signed [15:0] b_y,
    input  logic [14:0]        b_width,
    input  logic [14:0]        b_height,
    input  logic [14:0]        b_radius,
    input  logic [15:0]        rot_angle,
    output logic               done,
    output logic               hit
);

    localparam int NSTG = (CORDIC_STAGES < spht_pkg::ATAN_COUNT) ? CORDIC_STAGES
                                                                 : spht_pkg::ATAN_COUNT;
    localparam int LAT  = NSTG + 7;

    logic                   busy_reg;
    logic                   accept;
    logic                   vv [NSTG+1];
    spht_pkg::spht_cordic_t cc [NSTG+1];
    spht_pkg::spht_pld_t    pp [NSTG+1];

    assign accept = start && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy = busy_reg;

    spht_prep #(
        .COORD_BITS(COORD_BITS)
    ) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .kind       (kind),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_width    (a_width),
        .a_height   (a_height),
        .a_radius   (a_radius),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_width    (b_width),
        .b_height   (b_height),
        .b_radius   (b_radius),
        .rot_angle  (rot_angle),
        .out_valid  (vv[0]),
        .out_cordic (cc[0]),
        .out_pld    (pp[0])
    );

    for (genvar g = 0; g < NSTG; g++)
    begin : g_cell
        spht_cell #(
            .IDX(g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (vv[g]),
            .in_cordic  (cc[g]),
            .in_pld     (pp[g]),
            .out_valid  (vv[g+1]),
            .out_cordic (cc[g+1]),
            .out_pld    (pp[g+1])
        );
    end

    spht_rot u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vv[NSTG]),
        .in_cordic (cc[NSTG]),
        .in_pld    (pp[NSTG]),
        .done      (done),
        .hit       (hit)
    );

    // Every accepted item yields a result strobe, and every strobe comes from an accepted item.
    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("accepted item produced no result strobe");

    a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result strobe without an accepted item");

    a_other_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind != spht_pkg::KIND_RECT && kind != spht_pkg::KIND_CIRC
         && kind != spht_pkg::KIND_RA && kind != spht_pkg::KIND_AR) |-> ##LAT !hit)
        else $error("unsupported pair kind reported a hit");

    a_concentric: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == spht_pkg::KIND_CIRC && a_x == b_x && a_y == b_y)
        |-> ##LAT hit)
        else $error("concentric circles reported no hit");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the shape pair hit test pipeline.
module tb;

    localparam int  STAGES       = 16;
    localparam int  RESET_CYCLES = 6;
    localparam int  DRAIN_CYCLES = STAGES + 30;
    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  RANDOM_ITEMS = 1250;
    localparam logic [2:0] KIND_OTHER = 3'd4;
    localparam logic [2:0] KIND_LAST  = 3'd7;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam longint ONE_Q30  = 64'sd1 << 30;

    localparam logic [31:0] TURN_ATAN [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic [14:0]        a_width;
        logic [14:0]        a_height;
        logic [14:0]        a_radius;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic [14:0]        b_width;
        logic [14:0]        b_height;
        logic [14:0]        b_radius;
        logic [15:0]        rot_angle;
    } shape_pair_t;

    typedef struct {
        shape_pair_t pair;
        int          want;
    } pair_row_t;

    typedef struct {
        logic       hit;
        logic [2:0] kind;
    } hit_expect_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         kind = '0;
    logic signed [15:0] a_x = '0;
    logic signed [15:0] a_y = '0;
    logic [14:0]        a_width = '0;
    logic [14:0]        a_height = '0;
    logic [14:0]        a_radius = '0;
    logic signed [15:0] b_x = '0;
    logic signed [15:0] b_y = '0;
    logic [14:0]        b_width = '0;
    logic [14:0]        b_height = '0;
    logic [14:0]        b_radius = '0;
    logic [15:0]        rot_angle = '0;
    logic               done;
    logic               hit;

    int          pinned_hit = -1;
    int          error_count = 0;
    int          cycle_count = 0;
    hit_expect_t hit_expected_q[$];
    pair_row_t   directed_rows[$];

    shape_pair_hit_test u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_width   (a_width),
        .a_height  (a_height),
        .a_radius  (a_radius),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_width   (b_width),
        .b_height  (b_height),
        .b_radius  (b_radius),
        .rot_angle (rot_angle),
        .done      (done),
        .hit       (hit)
    );

    always #5 clk = ~clk;

    // Rotation-mode CORDIC on a turn fraction; the middle half turn is folded
    // by adding half a turn and negating the results.
    function automatic void cordic_sincos(input logic [15:0] ang, output longint cosv,
                                          output longint sinv);
        logic [31:0] z;
        logic        flip;
        longint      x;
        longint      y;
        longint      zs;
        longint      xs;
        longint      ys;
        z = {ang, 16'h0000};
        flip = (z[31:30] == 2'd1) || (z[31:30] == 2'd2);
        if (flip)
            z[31] = ~z[31];
        zs = longint'($signed(z));
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (zs >= 0)
            begin
                x = x - ys;
                y = y + xs;
                zs = zs - longint'(TURN_ATAN[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                zs = zs + longint'(TURN_ATAN[i]);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cosv = x;
        sinv = y;
    endfunction

    // The rectangle center is turned about the anchor, then tested against the
    // box [bx, bx + bw] x [by - bh/2, by + bh/2], all scaled by 2^30.
    function automatic logic rotated_box_overlap(input longint rx, input longint ry,
                                                 input longint rw, input longint rh,
                                                 input longint bx, input longint by,
                                                 input longint bw, input longint bh,
                                                 input logic [15:0] ang);
        longint c;
        longint s;
        longint dx;
        longint dy;
        longint cx;
        longint cy;
        cordic_sincos(ang, c, s);
        dx = rx - bx;
        dy = ry - by;
        cx = bx * ONE_Q30 + c * dx + s * dy;
        cy = by * ONE_Q30 - s * dx + c * dy;
        return (2 * cx - rw * ONE_Q30 <= (2 * bx + 2 * bw) * ONE_Q30)
            && (2 * bx * ONE_Q30 <= 2 * cx + rw * ONE_Q30)
            && (2 * cy - rh * ONE_Q30 <= (2 * by + bh) * ONE_Q30)
            && ((2 * by - bh) * ONE_Q30 <= 2 * cy + rh * ONE_Q30);
    endfunction

    function automatic logic predict_hit(input shape_pair_t p);
        longint ax;
        longint ay;
        longint aw;
        longint ah;
        longint bx;
        longint by;
        longint bw;
        longint bh;
        longint dx;
        longint dy;
        longint rsum;
        ax = longint'(p.a_x);
        ay = longint'(p.a_y);
        aw = longint'(p.a_width);
        ah = longint'(p.a_height);
        bx = longint'(p.b_x);
        by = longint'(p.b_y);
        bw = longint'(p.b_width);
        bh = longint'(p.b_height);
        case (p.kind)
            spht_pkg::KIND_RECT:
                return (2 * ax - aw <= 2 * bx + bw) && (2 * bx - bw <= 2 * ax + aw)
                    && (2 * ay - ah <= 2 * by + bh) && (2 * by - bh <= 2 * ay + ah);
            spht_pkg::KIND_CIRC:
            begin
                dx = ax - bx;
                dy = ay - by;
                rsum = longint'(p.a_radius) + longint'(p.b_radius);
                return dx * dx + dy * dy <= rsum * rsum;
            end
            spht_pkg::KIND_RA:
                return rotated_box_overlap(ax, ay, aw, ah, bx, by, bw, bh, p.rot_angle);
            spht_pkg::KIND_AR:
                return rotated_box_overlap(bx, by, bw, bh, ax, ay, aw, ah, p.rot_angle);
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic void add_row(input int k, input int ax, input int ay, input int aw,
                                    input int ah, input int ar, input int bx, input int by,
                                    input int bw, input int bh, input int br, input int ang,
                                    input int want);
        pair_row_t row;
        row.pair.kind      = 3'(k);
        row.pair.a_x       = 16'(ax);
        row.pair.a_y       = 16'(ay);
        row.pair.a_width   = 15'(aw);
        row.pair.a_height  = 15'(ah);
        row.pair.a_radius  = 15'(ar);
        row.pair.b_x       = 16'(bx);
        row.pair.b_y       = 16'(by);
        row.pair.b_width   = 15'(bw);
        row.pair.b_height  = 15'(bh);
        row.pair.b_radius  = 15'(br);
        row.pair.rot_angle = 16'(ang);
        row.want           = want;
        directed_rows.push_back(row);
    endfunction

    function automatic logic signed [15:0] near_coord(input logic signed [15:0] base,
                                                      input int span);
        return 16'(int'(base) + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [14:0] rand_size();
        if ($urandom_range(0, 9) == 0)
            return 15'($urandom);
        return 15'($urandom_range(0, 1023));
    endfunction

    // Mostly pairs placed close together so that hits and misses both occur,
    // with an occasional pair drawn over the whole coordinate range.
    function automatic shape_pair_t random_pair();
        shape_pair_t p;
        int          pick;
        logic        spread;
        pick = $urandom_range(0, 99);
        if (pick < 22)
            p.kind = spht_pkg::KIND_RECT;
        else if (pick < 44)
            p.kind = spht_pkg::KIND_CIRC;
        else if (pick < 66)
            p.kind = spht_pkg::KIND_RA;
        else if (pick < 88)
            p.kind = spht_pkg::KIND_AR;
        else
            p.kind = 3'($urandom_range(KIND_OTHER, KIND_LAST));
        spread = ($urandom_range(0, 7) == 0);
        p.a_x = 16'($urandom);
        p.a_y = 16'($urandom);
        p.a_width  = rand_size();
        p.a_height = rand_size();
        p.a_radius = rand_size();
        p.b_width  = rand_size();
        p.b_height = rand_size();
        p.b_radius = rand_size();
        p.b_x = spread ? 16'($urandom) : near_coord(p.a_x, 1500);
        p.b_y = spread ? 16'($urandom) : near_coord(p.a_y, 1500);
        p.rot_angle = 16'($urandom);
        return p;
    endfunction

    task automatic idle_gap(input int pct);
        while ($urandom_range(0, 99) < pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic send_pair(input shape_pair_t p, input int want);
        @(negedge clk);
        kind       <= p.kind;
        a_x        <= p.a_x;
        a_y        <= p.a_y;
        a_width    <= p.a_width;
        a_height   <= p.a_height;
        a_radius   <= p.a_radius;
        b_x        <= p.b_x;
        b_y        <= p.b_y;
        b_width    <= p.b_width;
        b_height   <= p.b_height;
        b_radius   <= p.b_radius;
        rot_angle  <= p.rot_angle;
        pinned_hit <= want;
        start      <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_all_results();
        while (hit_expected_q.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        shape_pair_t cur;
        hit_expect_t exp_item;
        if (done === 1'b1)
        begin
            if (hit_expected_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual hit=%b", $time, hit);
                error_count++;
            end
            else
            begin
                exp_item = hit_expected_q.pop_front();
                if (hit !== exp_item.hit)
                begin
                    $display("%0t: hit mismatch (kind %0d): expected %b, actual %b",
                             $time, exp_item.kind, exp_item.hit, hit);
                    error_count++;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            cur = '{kind, a_x, a_y, a_width, a_height, a_radius,
                    b_x, b_y, b_width, b_height, b_radius, rot_angle};
            exp_item.kind = kind;
            exp_item.hit = (pinned_hit >= 0) ? pinned_hit[0] : predict_hit(cur);
            hit_expected_q.push_back(exp_item);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int phase_pct [3];
        phase_pct = '{9, 54, 0};

        // Rectangles: coincident points, far corners, touching, one step apart and the largest sizes.
        add_row(spht_pkg::KIND_RECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        add_row(spht_pkg::KIND_RECT, -32768, -32768, 0, 0, 0, 32767, 32767, 0, 0, 0, 0, 0);
        add_row(spht_pkg::KIND_RECT, 0, 0, 32, 0, 0, 32, 0, 32, 0, 0, 0, 1);
        add_row(spht_pkg::KIND_RECT, 0, 0, 32, 0, 0, 33, 0, 32, 0, 0, 0, 0);
        add_row(spht_pkg::KIND_RECT, -32768, -32768, 32767, 32767, 32767,
                32767, 32767, 32767, 32767, 32767, 65535, 0);
        add_row(spht_pkg::KIND_RECT, 0, 0, 32767, 32767, 0, 0, 0, 32767, 32767, 0, 0, 1);
        // Circles: zero radii, exact touch, just apart, and the widest radius sum.
        add_row(spht_pkg::KIND_CIRC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        add_row(spht_pkg::KIND_CIRC, 0, 0, 0, 0, 25, 30, 40, 0, 0, 25, 0, 1);
        add_row(spht_pkg::KIND_CIRC, 0, 0, 0, 0, 25, 30, 40, 0, 0, 24, 0, 0);
        add_row(spht_pkg::KIND_CIRC, -32768, -32768, 0, 0, 32767, 32767, 32767, 0, 0,
                32767, 0, 0);
        add_row(spht_pkg::KIND_CIRC, -32768, -32768, 0, 0, 32767, -32768, -32768, 0, 0,
                32767, 0, 1);
        // Unused kinds never hit, even for coincident shapes.
        add_row(4, 0, 0, 100, 100, 100, 0, 0, 100, 100, 100, 0, 0);
        add_row(5, 0, 0, 100, 100, 100, 0, 0, 100, 100, 100, 0, 0);
        add_row(6, 0, 0, 100, 100, 100, 0, 0, 100, 100, 100, 0, 0);
        add_row(7, -1, -1, 32767, 32767, 32767, -1, -1, 32767, 32767, 32767, 65535, 0);
        // Rotated boxes at the quadrant boundaries and in between.
        add_row(spht_pkg::KIND_RA, 300, 10, 64, 64, 0, 0, 0, 640, 64, 0, 0, -1);
        add_row(spht_pkg::KIND_RA, 10, 300, 64, 64, 0, 0, 0, 640, 64, 0, 16384, -1);
        add_row(spht_pkg::KIND_RA, -300, 10, 64, 64, 0, 0, 0, 640, 64, 0, 32768, -1);
        add_row(spht_pkg::KIND_RA, 10, -300, 0, 0, 0, 0, 0, 640, 0, 0, 49152, -1);
        add_row(spht_pkg::KIND_RA, 200, -5, 16, 16, 0, 0, 0, 640, 64, 0, 65535, -1);
        add_row(spht_pkg::KIND_RA, 32767, 32767, 32767, 32767, 0, -32768, -32768, 32767,
                32767, 0, 40000, -1);
        add_row(spht_pkg::KIND_AR, 0, 0, 640, 64, 0, 200, 200, 64, 64, 0, 8192, -1);
        add_row(spht_pkg::KIND_AR, 0, 0, 640, 64, 0, -200, 200, 64, 64, 0, 24576, -1);
        add_row(spht_pkg::KIND_AR, -32768, -32768, 32767, 32767, 0, 32767, 32767, 32767,
                32767, 0, 57344, -1);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            idle_gap(phase_pct[0]);
            send_pair(directed_rows[i].pair, directed_rows[i].want);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            // Let the pipeline empty completely before each phase.
            @(negedge clk);
            start <= 1'b0;
            wait_all_results();
            for (int n = 0; n < RANDOM_ITEMS / 3 + 1; n++)
            begin
                idle_gap(phase_pct[phase]);
                send_pair(random_pair(), -1);
            end
        end

        @(negedge clk);
        start <= 1'b0;
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (hit_expected_q.size() != 0)
        begin
            $display("%0t: results missing: expected %0d more, actual 0",
                     $time, hit_expected_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
